// ===== hdl/cpm_pkg.sv =====
// Package for the pixel chain position map.
// Holds the stage payload types and the fixed field widths shared by all stages.
// No dependencies.
package cpm_pkg;

	localparam int COL_MAX  = 32;
	localparam int PAIR_MAX = COL_MAX / 2;
	localparam int ENABLE_W = 9;
	localparam int CNT_W    = 6;
	localparam int PROD_W   = 15;
	localparam int OFF_W    = 9;
	localparam int COL_W    = 5;
	localparam int ROW_W    = 8;
	localparam int POS_W    = 12;

	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic               req;
		logic               bad;
		logic [ROW_W-1:0]   row;
		logic [POS_W-1:0]   pos;
		logic [COL_MAX-1:0] act;
		logic [COL_MAX-1:0] below;
		logic [COL_MAX-1:0] ge;
	} s1_t;

	typedef struct packed {
		logic               req;
		logic               bad;
		logic [ROW_W-1:0]   row;
		logic [POS_W-1:0]   pos;
		logic [COL_MAX-1:0] act;
		cnt_t               total;
		cnt_t               rank;
		cnt_t               blk;
		cnt_t [COL_MAX-1:0] suf;
	} s2_t;

	typedef struct packed {
		logic               req;
		logic               bad;
		logic [ROW_W-1:0]   row;
		logic [POS_W-1:0]   pos;
		logic               rank_odd;
		logic               blk_odd;
		logic [PROD_W-1:0]  prod;
		logic [COL_MAX-1:0] match;
	} s3_t;

	typedef struct packed {
		logic             bad;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [POS_W-1:0] pos;
	} res_t;

endpackage

// ===== hdl/cpm_decode.sv =====
// First stage: column activity, forward checks and block threshold compares.
// Depends on cpm_pkg.
module cpm_decode #(
	parameter int NUM_COLUMNS = 18,
	parameter int NUM_ROWS    = 160
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          req_type,
	input  logic [cpm_pkg::COL_W-1:0]     in_column,
	input  logic [cpm_pkg::ROW_W-1:0]     in_row,
	input  logic [cpm_pkg::POS_W-1:0]     in_position,
	input  logic [cpm_pkg::ENABLE_W-1:0]  column_pair_enable,
	output logic                          out_valid,
	input  logic                          out_ready,
	output cpm_pkg::s1_t                  out_data
);
	import cpm_pkg::*;

	logic [PAIR_MAX-1:0] en_ext;
	logic [COL_MAX-1:0]  act;
	logic [COL_MAX-1:0]  below;
	logic [COL_MAX-1:0]  ge;
	logic                fwd_bad;
	logic                valid_s1;
	s1_t                 data_s1;

	always_comb begin
		en_ext = PAIR_MAX'(column_pair_enable);
		for (int c = 0; c < COL_MAX; c++) begin
			act[c]   = (c < NUM_COLUMNS) && en_ext[c/2];
			below[c] = act[c] && (COL_W'(c) < in_column);
			ge[c]    = (c < NUM_COLUMNS) &&
				(PROD_W'(in_position) >= PROD_W'((c + 1) * NUM_ROWS));
		end
		fwd_bad = !act[in_column] || ({2'b00, in_row} >= 10'(NUM_ROWS));
	end

	assign in_ready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.req   <= req_type;
			data_s1.bad   <= fwd_bad;
			data_s1.row   <= in_row;
			data_s1.pos   <= in_position;
			data_s1.act   <= act;
			data_s1.below <= below;
			data_s1.ge    <= ge;
		end
	end

	assign out_valid = valid_s1;
	assign out_data  = data_s1;

endmodule

// ===== hdl/cpm_count.sv =====
// Second stage: population counts for the active total, rank, block and suffixes.
// Depends on cpm_pkg.
module cpm_count (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  cpm_pkg::s1_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output cpm_pkg::s2_t out_data
);
	import cpm_pkg::*;

	cnt_t               total;
	cnt_t               rank;
	cnt_t               blk;
	cnt_t [COL_MAX-1:0] suf;
	logic               valid_s2;
	s2_t                data_s2;

	always_comb begin
		total = CNT_W'($countones(in_data.act));
		rank  = CNT_W'($countones(in_data.below));
		blk   = CNT_W'($countones(in_data.ge));
		for (int c = 0; c < COL_MAX; c++) begin
			suf[c] = CNT_W'($countones(in_data.act >> c));
		end
	end

	assign in_ready = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s2.req   <= in_data.req;
			data_s2.bad   <= in_data.bad;
			data_s2.row   <= in_data.row;
			data_s2.pos   <= in_data.pos;
			data_s2.act   <= in_data.act;
			data_s2.total <= total;
			data_s2.rank  <= rank;
			data_s2.blk   <= blk;
			data_s2.suf   <= suf;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule

// ===== hdl/cpm_scale.sv =====
// Third stage: block times row count, range check and active column match.
// Depends on cpm_pkg.
module cpm_scale #(
	parameter int NUM_ROWS = 160
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  cpm_pkg::s2_t in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output cpm_pkg::s3_t out_data
);
	import cpm_pkg::*;

	cnt_t               fwd_blk;
	cnt_t               mult_in;
	cnt_t               target;
	logic [PROD_W-1:0]  prod;
	logic [COL_MAX-1:0] match;
	logic               bad;
	logic               valid_s3;
	s3_t                data_s3;

	always_comb begin
		fwd_blk = in_data.total - in_data.rank - CNT_W'(in_data.rank[0]);
		mult_in = in_data.req ? in_data.blk : fwd_blk;
		prod    = PROD_W'(mult_in) * PROD_W'(NUM_ROWS);
		target  = in_data.blk + CNT_W'(1);
		for (int c = 0; c < COL_MAX; c++) begin
			match[c] = in_data.act[c] && (in_data.suf[c] == target);
		end
		bad = in_data.req ? (in_data.blk >= in_data.total) : in_data.bad;
	end

	assign in_ready = !valid_s3 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s3.req      <= in_data.req;
			data_s3.bad      <= bad;
			data_s3.row      <= in_data.row;
			data_s3.pos      <= in_data.pos;
			data_s3.rank_odd <= in_data.rank[0];
			data_s3.blk_odd  <= in_data.blk[0];
			data_s3.prod     <= prod;
			data_s3.match    <= match;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

endmodule

// ===== hdl/cpm_finish.sv =====
// Fourth stage: final position, row offset and column encode into the output register.
// Depends on cpm_pkg.
module cpm_finish #(
	parameter int NUM_ROWS = 160
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cpm_pkg::s3_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output cpm_pkg::res_t out_data
);
	import cpm_pkg::*;

	logic [PROD_W-1:0] fwd_pos;
	logic [PROD_W-1:0] diff;
	logic [OFF_W-1:0]  off;
	logic [OFF_W-1:0]  inv_row;
	logic [COL_W-1:0]  col;
	res_t              res;
	logic              valid_s4;
	res_t              data_s4;

	always_comb begin
		if (in_data.rank_odd) begin
			fwd_pos = in_data.prod + PROD_W'(in_data.row);
		end else begin
			fwd_pos = in_data.prod - PROD_W'(in_data.row) - PROD_W'(1);
		end
		diff    = PROD_W'(in_data.pos) - in_data.prod;
		off     = diff[OFF_W-1:0];
		inv_row = in_data.blk_odd ? (OFF_W'(NUM_ROWS - 1) - off) : off;
		col     = '0;
		for (int c = 0; c < COL_MAX; c++) begin
			if (in_data.match[c]) begin
				col = col | COL_W'(c);
			end
		end
		res = '0;
		res.bad = in_data.bad;
		if (!in_data.bad) begin
			if (in_data.req) begin
				res.col = col;
				res.row = inv_row[ROW_W-1:0];
			end else begin
				res.pos = fwd_pos[POS_W-1:0];
			end
		end
	end

	assign in_ready = !valid_s4 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (in_ready) begin
			valid_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s4 <= res;
		end
	end

	assign out_valid = valid_s4;
	assign out_data  = data_s4;

endmodule

// ===== hdl/pixel_chain_position_map.sv =====
// Top level of the pixel chain position map: stream ports, enable register, four stages.
// Depends on cpm_pkg, cpm_decode, cpm_count, cpm_scale and cpm_finish.
//
// Channel   Direction  Signals                         Contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser  one request word
// m_*       out        m_tvalid m_tready m_tdata m_tuser  one result word
// cfg_*     in         cfg_wr_en cfg_wr_data              column pair enables
//
// Every word passes four register stages, and a new request is taken every cycle
// while the result side does not stall.
// The stages are decode, population count, row scaling and final assembly.
// Reset clears the stage valid bits and the enable register; any word in flight is dropped.
// A stall on the result side holds the last stage and backs up only full stages.
module pixel_chain_position_map #(
	parameter int NUM_COLUMNS = 18,
	parameter int NUM_ROWS    = 160
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// in_column [4:0], in_row [12:5], in_position [24:13], zero fill above.
	input  logic [31:0] s_tdata,
	// req_type.
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_position [11:0], out_column [16:12], out_row [24:17], zero fill above.
	output logic [31:0] m_tdata,
	// bad_request.
	output logic        m_tuser,
	input  logic        cfg_wr_en,
	input  logic [8:0]  cfg_wr_data
);
	import cpm_pkg::*;

	logic [ENABLE_W-1:0] column_pair_enable_q;
	logic                v1, r1, v2, r2, v3, r3;
	s1_t                 d1;
	s2_t                 d2;
	s3_t                 d3;
	res_t                res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_pair_enable_q <= '0;
		end else if (cfg_wr_en) begin
			column_pair_enable_q <= cfg_wr_data;
		end
	end

	cpm_decode #(
		.NUM_COLUMNS(NUM_COLUMNS),
		.NUM_ROWS(NUM_ROWS)
	) u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.req_type(s_tuser),
		.in_column(s_tdata[4:0]),
		.in_row(s_tdata[12:5]),
		.in_position(s_tdata[24:13]),
		.column_pair_enable(column_pair_enable_q),
		.out_valid(v1),
		.out_ready(r1),
		.out_data(d1)
	);

	cpm_count u_count (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v1),
		.in_ready(r1),
		.in_data(d1),
		.out_valid(v2),
		.out_ready(r2),
		.out_data(d2)
	);

	cpm_scale #(
		.NUM_ROWS(NUM_ROWS)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v2),
		.in_ready(r2),
		.in_data(d2),
		.out_valid(v3),
		.out_ready(r3),
		.out_data(d3)
	);

	cpm_finish #(
		.NUM_ROWS(NUM_ROWS)
	) u_finish (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(v3),
		.in_ready(r3),
		.in_data(d3),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_data(res)
	);

	assign m_tdata = {7'b0, res.row, res.col, res.pos};
	assign m_tuser = res.bad;

`ifndef SYNTHESIS
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == 32'd0)
		else $error("bad result carries nonzero fields");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output stage is empty");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> 32'(m_tdata[16:12]) < NUM_COLUMNS)
		else $error("result column beyond column count");
`endif

endmodule
